// ===== hw/rtl/assert_macros.svh =====
// concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/torq_pkg.sv =====
package torq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int REQ_W       = 4;
  localparam int STAMP_W     = 15;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OWN_PROCESS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PROCESS_COUNT = 1'b1;

  localparam logic [CFG_W-1:0] PROCESS_COUNT_RESET = 5'd16;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  typedef struct packed {
    logic load;
    logic compare;
    logic update;
  } dp_cmd_t;

endpackage

// ===== hw/rtl/torq_controller.sv =====
`include "assert_macros.svh"

module torq_controller (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output torq_pkg::dp_cmd_t cmd,
  output logic              out_strobe
);
  import torq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_UPDATE
  } state_t;

  state_t state_r, state_nxt;
  logic   strobe_r, strobe_nxt;

  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_COMPARE;
      end
      ST_COMPARE: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt  = ST_IDLE;
        strobe_nxt = 1'b1;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.load    = start && (state_r == ST_IDLE);
  assign cmd.compare = (state_r == ST_COMPARE);
  assign cmd.update  = (state_r == ST_UPDATE);
  assign out_strobe  = strobe_r;

  `ASSERT_IMPL(a_accept_gives_word, clk, rst_n, start && !busy, ##3 out_strobe)
  `ASSERT_NEXT(a_accept_goes_busy, clk, rst_n, start && !busy, busy && !out_strobe)

endmodule

// ===== hw/rtl/torq_datapath.sv =====
module torq_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  torq_pkg::dp_cmd_t               cmd,
  input  logic                            in_opcode,
  input  logic [torq_pkg::REQ_W-1:0]      in_requester,
  input  logic [torq_pkg::STAMP_W-1:0]    in_request_stamp,
  input  logic                            cfg_we,
  input  logic [torq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [torq_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_must_wait,
  output logic                            out_send_reply,
  output logic                            out_head_valid,
  output logic [torq_pkg::REQ_W-1:0]      out_head_requester,
  output logic                            out_dropped
);
  import torq_pkg::*;

  logic [REQ_W-1:0]   own_r;
  logic [CFG_W-1:0]   count_r;
  logic [CNT_W-1:0]   n_c;
  logic [IDX_W-1:0]   tail_idx;

  logic               op_r;
  logic [REQ_W-1:0]   req_r;
  logic [STAMP_W-1:0] stamp_r;

  logic [QUEUE_DEPTH-1:0] valid_r, valid_nxt;
  logic [REQ_W-1:0]       slot_req_r   [QUEUE_DEPTH];
  logic [STAMP_W-1:0]     slot_stamp_r [QUEUE_DEPTH];
  logic [REQ_W-1:0]       slot_req_nxt   [QUEUE_DEPTH];
  logic [STAMP_W-1:0]     slot_stamp_nxt [QUEUE_DEPTH];

  logic [QUEUE_DEPTH-1:0] stop_c, stop_r, neg_c, first_c, after_c;
  logic                   full_pass;
  logic                   drop_c, reply_c;

  logic must_wait_r, send_reply_r, head_valid_r, dropped_r;
  logic [REQ_W-1:0] head_req_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_r   <= '0;
      count_r <= PROCESS_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OWN_PROCESS:   own_r   <= cfg_data[REQ_W-1:0];
        REG_PROCESS_COUNT: count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // slots in use, saturated
  always_comb begin
    if (count_r == '0) begin
      n_c = CNT_W'(1);
    end else if (int'(count_r) > QUEUE_DEPTH) begin
      n_c = CNT_W'(QUEUE_DEPTH);
    end else begin
      n_c = CNT_W'(count_r);
    end
  end
  assign tail_idx = IDX_W'(n_c - CNT_W'(1));

  // input word latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_opcode;
      req_r   <= in_requester;
      stamp_r <= in_request_stamp;
    end
  end

  // per-slot compare
  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      stop_c[k] = (CNT_W'(k) < n_c) &&
                  !(valid_r[k] &&
                    ((slot_stamp_r[k] < stamp_r) ||
                     ((slot_stamp_r[k] == stamp_r) && (slot_req_r[k] < req_r))));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.compare) stop_r <= stop_c;
  end

  // insert position: first stop and everything at or after it
  assign neg_c     = '0 - stop_r;
  assign first_c   = stop_r & neg_c;
  assign after_c   = stop_r | neg_c;
  assign full_pass = (stop_r == '0);

  always_comb begin
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      valid_nxt[k]      = valid_r[k];
      slot_req_nxt[k]   = slot_req_r[k];
      slot_stamp_nxt[k] = slot_stamp_r[k];
    end
    if (op_r == OP_INSERT) begin
      if (!full_pass) begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
          if (first_c[k]) begin
            valid_nxt[k]      = 1'b1;
            slot_req_nxt[k]   = req_r;
            slot_stamp_nxt[k] = stamp_r;
          end
        end
        for (int k = 1; k < QUEUE_DEPTH; k++) begin
          if (after_c[k] && !first_c[k] && (CNT_W'(k) < n_c)) begin
            valid_nxt[k]      = valid_r[k-1];
            slot_req_nxt[k]   = slot_req_r[k-1];
            slot_stamp_nxt[k] = slot_stamp_r[k-1];
          end
        end
      end
    end else begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        if (CNT_W'(k) < n_c - CNT_W'(1)) begin
          valid_nxt[k]      = valid_r[k+1];
          slot_req_nxt[k]   = slot_req_r[k+1];
          slot_stamp_nxt[k] = slot_stamp_r[k+1];
        end
      end
      valid_nxt[tail_idx]      = 1'b0;
      slot_req_nxt[tail_idx]   = '0;
      slot_stamp_nxt[tail_idx] = '0;
    end
  end

  assign drop_c  = (op_r == OP_INSERT) && (full_pass || valid_r[tail_idx]);
  assign reply_c = (op_r == OP_INSERT) && (req_r != own_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.update) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      for (int k = 0; k < QUEUE_DEPTH; k++) begin
        slot_req_r[k]   <= slot_req_nxt[k];
        slot_stamp_r[k] <= slot_stamp_nxt[k];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      head_valid_r <= valid_nxt[0];
      head_req_r   <= valid_nxt[0] ? slot_req_nxt[0] : '0;
      must_wait_r  <= valid_nxt[0] && (slot_req_nxt[0] != own_r);
      send_reply_r <= reply_c;
      dropped_r    <= drop_c;
    end
  end

  assign out_must_wait      = must_wait_r;
  assign out_send_reply     = send_reply_r;
  assign out_head_valid     = head_valid_r;
  assign out_head_requester = head_req_r;
  assign out_dropped        = dropped_r;

endmodule

// ===== hw/rtl/timestamp_ordered_request_queue.sv =====
// the input word is captured at the accepting edge, then the slot compare and the shift update follow,
// the update registering the result word; a new word is accepted only while the queue is not busy
// the per-slot compare result is registered before the shift step
// results stand for one cycle under out_strobe; the receiver cannot stall
// synchronous active-low reset empties the queue, own_process 0, process_count 16
`include "assert_macros.svh"

module timestamp_ordered_request_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [torq_pkg::REQ_W-1:0]      in_requester,
  input  logic [torq_pkg::STAMP_W-1:0]    in_request_stamp,
  input  logic                            cfg_we,
  input  logic [torq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [torq_pkg::CFG_W-1:0]      cfg_data,
  output logic                            out_strobe,
  output logic                            out_must_wait,
  output logic                            out_send_reply,
  output logic                            out_head_valid,
  output logic [torq_pkg::REQ_W-1:0]      out_head_requester,
  output logic                            out_dropped
);
  import torq_pkg::*;

  dp_cmd_t cmd;

  torq_controller u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .out_strobe (out_strobe)
  );

  torq_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_opcode          (in_opcode),
    .in_requester       (in_requester),
    .in_request_stamp   (in_request_stamp),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_must_wait      (out_must_wait),
    .out_send_reply     (out_send_reply),
    .out_head_valid     (out_head_valid),
    .out_head_requester (out_head_requester),
    .out_dropped        (out_dropped)
  );

  `ASSERT_IMPL(a_drop_needs_head, clk, rst_n, out_strobe && out_dropped, out_head_valid)
  `ASSERT_IMPL(a_wait_needs_head, clk, rst_n, out_strobe && out_must_wait, out_head_valid)

endmodule
